// ===== hdl/dmm_pkg.sv =====
package dmm_pkg;

	// Widths fixed by the item formats and the size registers.
	localparam int DIM_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IN_ELEM_W = 32;
	localparam int RESULT_W  = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

	// Matrix selector carried by each input item.
	localparam logic ACT_LEFT  = 1'b0;
	localparam logic ACT_RIGHT = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef struct packed {
		logic                        action;
		logic signed [IN_ELEM_W-1:0] element;
	} in_item_t;

	typedef struct packed {
		logic signed [RESULT_W-1:0] product_value;
		logic                       last_of_run;
	} out_item_t;

	// Markers that travel with each multiply-accumulate through the pipeline.
	typedef struct packed {
		logic first;
		logic last;
		logic end_run;
	} mac_flags_t;

	typedef struct packed {
		logic       wr_left;
		logic       wr_right;
		logic       issue;
		mac_flags_t flags;
	} ctl_cmd_t;

	typedef struct packed {
		logic busy;
		logic advance;
	} dp_status_t;

endpackage

// ===== hdl/dmm_ctrl.sv =====
module dmm_ctrl import dmm_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [DIM_W-1:0]                       rows_used,
	input  logic [DIM_W-1:0]                       inner_used,
	input  logic [DIM_W-1:0]                       cols_used,
	input  logic                                   item_valid,
	input  logic                                   item_action,
	output logic                                   item_ready,
	output ctl_cmd_t                               cmd,
	output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
	output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] a_addr,
	output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] b_addr,
	input  dp_status_t                             status
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > 2 * DIM_W) ? CNT_W : 2 * DIM_W;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	state_t             state_q;
	logic [CNT_W-1:0]   left_count_q;
	logic [CNT_W-1:0]   right_count_q;
	logic [DIM_W-1:0]   i_q;
	logic [DIM_W-1:0]   j_q;
	logic [DIM_W-1:0]   p_q;
	logic [ADDR_W-1:0]  a_row_q;
	logic [ADDR_W-1:0]  a_idx_q;
	logic [ADDR_W-1:0]  b_idx_q;

	logic [DIM_W-1:0]   m_dim;
	logic [DIM_W-1:0]   k_dim;
	logic [DIM_W-1:0]   n_dim;
	logic [2*DIM_W-1:0] mk;
	logic [2*DIM_W-1:0] kn;
	logic               accept;
	logic               wr_left;
	logic               wr_right;
	logic [CMP_W-1:0]   right_next;
	logic               trigger;
	logic               issue;
	logic               p_end;
	logic               j_end;
	logic               i_end;

	assign m_dim = clamp_dim(rows_used);
	assign k_dim = clamp_dim(inner_used);
	assign n_dim = clamp_dim(cols_used);
	assign mk    = m_dim * k_dim;
	assign kn    = k_dim * n_dim;

	assign item_ready = (state_q == ST_LOAD);
	assign accept     = item_valid && item_ready;

	assign wr_left  = accept && (item_action == ACT_LEFT) &&
		(CMP_W'(left_count_q) < CMP_W'(mk));
	assign wr_right = accept && (item_action == ACT_RIGHT) &&
		(CMP_W'(right_count_q) < CMP_W'(kn));

	assign right_next = CMP_W'(right_count_q) + CMP_W'(wr_right);
	assign trigger    = accept && (item_action == ACT_RIGHT) && (right_next >= CMP_W'(kn));

	assign wr_addr = (item_action == ACT_LEFT) ? left_count_q[ADDR_W-1:0] :
		right_count_q[ADDR_W-1:0];

	assign p_end = (p_q == k_dim - DIM_W'(1));
	assign j_end = (j_q == n_dim - DIM_W'(1));
	assign i_end = (i_q == m_dim - DIM_W'(1));

	assign issue  = (state_q == ST_ISSUE) && status.advance;
	assign a_addr = a_idx_q;
	assign b_addr = b_idx_q;

	always_comb begin
		cmd               = '0;
		cmd.wr_left       = wr_left;
		cmd.wr_right      = wr_right;
		cmd.issue         = issue;
		cmd.flags.first   = (p_q == '0);
		cmd.flags.last    = p_end;
		cmd.flags.end_run = p_end && j_end && i_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			left_count_q  <= '0;
			right_count_q <= '0;
			i_q           <= '0;
			j_q           <= '0;
			p_q           <= '0;
			a_row_q       <= '0;
			a_idx_q       <= '0;
			b_idx_q       <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (trigger) begin
						left_count_q  <= '0;
						right_count_q <= '0;
						i_q           <= '0;
						j_q           <= '0;
						p_q           <= '0;
						a_row_q       <= '0;
						a_idx_q       <= '0;
						b_idx_q       <= '0;
						state_q       <= ST_ISSUE;
					end else begin
						if (wr_left) begin
							left_count_q <= left_count_q + CNT_W'(1);
						end
						if (wr_right) begin
							right_count_q <= right_count_q + CNT_W'(1);
						end
					end
				end
				ST_ISSUE: begin
					if (issue) begin
						if (!p_end) begin
							p_q     <= p_q + DIM_W'(1);
							a_idx_q <= a_idx_q + ADDR_W'(1);
							b_idx_q <= b_idx_q + ADDR_W'(n_dim);
						end else if (!j_end) begin
							p_q     <= '0;
							j_q     <= j_q + DIM_W'(1);
							a_idx_q <= a_row_q;
							b_idx_q <= ADDR_W'(j_q) + ADDR_W'(1);
						end else begin
							p_q     <= '0;
							j_q     <= '0;
							i_q     <= i_q + DIM_W'(1);
							a_row_q <= a_row_q + ADDR_W'(k_dim);
							a_idx_q <= a_row_q + ADDR_W'(k_dim);
							b_idx_q <= '0;
							if (i_end) begin
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (!status.busy) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== hdl/dmm_datapath.sv =====
module dmm_datapath import dmm_pkg::*; #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [IN_ELEM_W-1:0]                   element,
	input  ctl_cmd_t                               cmd,
	input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
	input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] a_addr,
	input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] b_addr,
	output dp_status_t                             status,
	output out_item_t                              result,
	output logic                                   result_valid,
	input  logic                                   result_ready
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;

	logic signed [ELEM_WIDTH-1:0]   left_mem [DEPTH];
	logic signed [ELEM_WIDTH-1:0]   right_mem [DEPTH];

	logic signed [ELEM_WIDTH-1:0]   a_s1;
	logic signed [ELEM_WIDTH-1:0]   b_s1;
	mac_flags_t                     flags_s1;
	logic                           valid_s1;
	logic signed [RESULT_W-1:0]     prod_s2;
	mac_flags_t                     flags_s2;
	logic                           valid_s2;
	logic signed [RESULT_W-1:0]     acc_q;
	out_item_t                      out_q;
	logic                           out_valid_q;

	logic                           advance;
	logic signed [2*ELEM_WIDTH-1:0] mul_full;
	logic signed [RESULT_W-1:0]     acc_sum;

	// The whole MAC pipeline moves only when the output slot is free or emptying.
	assign advance = !out_valid_q || result_ready;

	always_comb begin
		status.advance = advance;
		status.busy    = valid_s1 || valid_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_left) begin
			left_mem[wr_addr] <= element[ELEM_WIDTH-1:0];
		end
		if (cmd.wr_right) begin
			right_mem[wr_addr] <= element[ELEM_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			a_s1     <= left_mem[a_addr];
			b_s1     <= right_mem[b_addr];
			flags_s1 <= cmd.flags;
		end
	end

	assign mul_full = a_s1 * b_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s2  <= RESULT_W'(mul_full);
			flags_s2 <= flags_s1;
		end
	end

	assign acc_sum = (flags_s2.first ? '0 : acc_q) + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= cmd.issue;
				valid_s2 <= valid_s1;
				if (valid_s2) begin
					acc_q <= acc_sum;
				end
			end
			if (advance && valid_s2 && flags_s2.last) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2 && flags_s2.last) begin
			out_q.product_value <= acc_sum;
			out_q.last_of_run   <= flags_s2.end_run;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

// ===== hdl/dense_matrix_multiply.sv =====
// Dense integer matrix multiply, C = A * B, for matrices of up to MAX_DIM
// on a side. The sizes M, K and N come from three 4-bit registers written
// over the plain write port; zero acts as one and values above MAX_DIM act
// as MAX_DIM. The user must change sizes only while the block is idle;
// the block itself does not enforce this. Input transfers carry one
// element each: all of A row-major (action 0), then all of B row-major
// (action 1). Loading takes one transfer per cycle. The transfer that
// completes B starts the multiply walk, during which the input is held
// off. The walk does one multiply-accumulate per cycle while the output
// is not stalled, through a single multiplier fed by the two element
// memories. C leaves row-major, last_of_run marking its final entry.
// Products and sums wrap in 64-bit two's complement.
// If the receiver stalls, the finished result waits in the output register
// and the whole multiply pipeline freezes with it, so nothing is lost.
// Reset clears the counts, the accumulator and all valid flags and sets all
// three sizes to 8; the element memories are not cleared and hold whatever
// was last written.
module dense_matrix_multiply import dmm_pkg::*; #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  in_item_t             item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output out_item_t            result
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Size registers, taken as written; clamping happens in the controller.
	logic [DIM_W-1:0]  rows_q;
	logic [DIM_W-1:0]  inner_q;
	logic [DIM_W-1:0]  cols_q;

	ctl_cmd_t          cmd;
	dp_status_t        status;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] a_addr;
	logic [ADDR_W-1:0] b_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_ROWS:  rows_q  <= cfg_data;
				REG_INNER: inner_q <= cfg_data;
				REG_COLS:  cols_q  <= cfg_data;
				default: begin
					// Writes to unused indexes are ignored.
				end
			endcase
		end
	end

	// The controller owns the load counts and the (i, j, p) walk; it hands
	// addresses and per-product markers to the datapath.
	dmm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.rows_used   (rows_q),
		.inner_used  (inner_q),
		.cols_used   (cols_q),
		.item_valid  (item_valid),
		.item_action (item.action),
		.item_ready  (item_ready),
		.cmd         (cmd),
		.wr_addr     (wr_addr),
		.a_addr      (a_addr),
		.b_addr      (b_addr),
		.status      (status)
	);

	// The datapath holds both element memories, the multiplier, the
	// accumulator and the output register.
	dmm_datapath #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.element      (item.element),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.a_addr       (a_addr),
		.b_addr       (b_addr),
		.status       (status),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule
